// ===== rtl/olt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olt_pkg: shared types and constants for the ordered list table
// Sizes, operation and status codes, word formats and the command and
// status structs between controller and datapath.
// ----------------------------------------------------------------------------
package olt_pkg;

    // list size and derived widths
    localparam int LIST_DEPTH = 32;
    localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int POS_W      = 6;
    localparam int VAL_W      = 64;
    localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [1:0] {
        MODE_INSERT,
        MODE_ERASE,
        MODE_FIND,
        MODE_CLEAR
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK,
        ST_MATCH,
        ST_RANGE,
        ST_FULL
    } t_status;

    // input word
    typedef struct packed {
        t_mode                    mode;
        logic [POS_W-1:0]         position;
        logic signed [VAL_W-1:0]  value;
    } t_in_word;

    // result word
    typedef struct packed {
        t_status                  status;
        logic [POS_W-1:0]         match_position;
        logic                     last;
        logic [POS_W-1:0]         entry_total;
    } t_out_word;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_SHIFT,
        S_INS_PUT,
        S_ERS_SHIFT,
        S_ERS_END,
        S_FIND,
        S_FIND_END,
        S_REPORT
    } t_state;

    // index setup at the start of an operation
    typedef enum logic [1:0] {
        SETUP_NONE,
        SETUP_INS,
        SETUP_ERS,
        SETUP_FIND
    } t_setup;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_CLR
    } t_cnt_op;

    // source of the next result word
    typedef enum logic [1:0] {
        OUT_NONE,
        OUT_STATUS,
        OUT_PEND_MID,
        OUT_PEND_LAST
    } t_out_sel;

    typedef struct packed {
        logic      load_item;
        t_setup    setup;
        logic      ins_step;
        logic      ers_step;
        logic      put_value;
        logic      find_step;
        t_cnt_op   cnt_op;
        logic      set_status;
        t_status   status;
        t_out_sel  out_sel;
    } t_dp_cmd;

    typedef struct packed {
        t_mode             mode;
        logic              pos_zero;
        logic              pos_past_end;
        logic              full;
        logic              ins_more;
        logic              ers_more;
        logic              wr_pend;
        logic              hit;
        logic              pend_vld;
        logic              scan_end;
        logic              out_free;
        logic [CNT_W-1:0]  count;
    } t_dp_sts;

endpackage

// ===== rtl/olt_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olt_if: valid/ready channels of the ordered list table
// One interface for input words and one for result words.
// ----------------------------------------------------------------------------
interface olt_in_if import olt_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

interface olt_out_if import olt_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

// ===== rtl/olt_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olt_datapath: entry memory, index counters and result register
// Holds the list in a memory with one write and one registered read per
// cycle; shifts move one entry per cycle, find compares one entry per cycle unless a match waits on a stalled output.
// ----------------------------------------------------------------------------
module olt_datapath import olt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    output t_dp_sts   o_sts,
    input  t_in_word  i_in_word,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output t_out_word o_out_word
);

    // latched item
    t_mode               r_mode;
    logic [CMP_W-1:0]    r_pos;
    logic [VAL_W-1:0]    r_value;

    // list state and walk
    logic [VAL_W-1:0]    r_mem [LIST_DEPTH];
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic                r_wr_pend;
    logic [ADDR_W-1:0]   r_wr_addr;
    logic [VAL_W-1:0]    r_rdata;
    logic                r_rd_vld;
    logic [ADDR_W-1:0]   r_chk_idx;
    logic                r_pend_vld;
    logic [CNT_W-1:0]    r_pend_pos;
    t_status             r_status;
    logic                r_out_vld;
    t_out_word           r_out_word, n_out_word;

    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [VAL_W-1:0]    wr_data;
    logic                scan_end;
    logic                hit;
    logic                out_free;

    assign scan_end = (r_idx == r_count);
    assign hit      = r_rd_vld && (r_rdata == r_value);
    assign out_free = !r_out_vld || i_out_ready;

    // memory port selection
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_idx[ADDR_W-1:0];
        if (i_cmd.ins_step) begin
            rd_en   = 1'b1;
            rd_addr = ADDR_W'(r_idx - 1'b1);
        end else if (i_cmd.ers_step) begin
            rd_en   = 1'b1;
            rd_addr = ADDR_W'(r_idx + 1'b1);
        end else if (i_cmd.find_step && !scan_end) begin
            rd_en   = 1'b1;
        end
        wr_en   = r_wr_pend || i_cmd.put_value;
        wr_addr = r_wr_pend ? r_wr_addr : ADDR_W'(r_pos);
        wr_data = r_wr_pend ? r_rdata : r_value;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // index and count
    always_comb begin
        n_idx = r_idx;
        unique case (i_cmd.setup)
            SETUP_INS:  n_idx = r_count;
            SETUP_ERS:  n_idx = CNT_W'(r_pos - 1'b1);
            SETUP_FIND: n_idx = '0;
            SETUP_NONE: begin
                if (i_cmd.ins_step) begin
                    n_idx = r_idx - 1'b1;
                end else if (i_cmd.ers_step || (i_cmd.find_step && !scan_end)) begin
                    n_idx = r_idx + 1'b1;
                end
            end
        endcase
        unique case (i_cmd.cnt_op)
            CNT_HOLD: n_count = r_count;
            CNT_INC:  n_count = r_count + 1'b1;
            CNT_DEC:  n_count = r_count - 1'b1;
            CNT_CLR:  n_count = '0;
        endcase
    end

    // next result word
    always_comb begin
        n_out_word = r_out_word;
        unique case (i_cmd.out_sel)
            OUT_NONE: ;
            OUT_STATUS: begin
                n_out_word.status         = r_status;
                n_out_word.match_position = '0;
                n_out_word.last           = 1'b1;
                n_out_word.entry_total    = POS_W'(r_count);
            end
            OUT_PEND_MID: begin
                n_out_word.status         = ST_MATCH;
                n_out_word.match_position = POS_W'(r_pend_pos);
                n_out_word.last           = 1'b0;
                n_out_word.entry_total    = POS_W'(r_count);
            end
            OUT_PEND_LAST: begin
                n_out_word.status         = ST_MATCH;
                n_out_word.match_position = POS_W'(r_pend_pos);
                n_out_word.last           = 1'b1;
                n_out_word.entry_total    = POS_W'(r_count);
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_idx      <= '0;
            r_wr_pend  <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_wr_pend <= i_cmd.ins_step || i_cmd.ers_step;
            if (i_cmd.setup == SETUP_FIND) begin
                r_rd_vld   <= 1'b0;
                r_pend_vld <= 1'b0;
            end else if (i_cmd.find_step) begin
                r_rd_vld <= !scan_end;
                if (hit) begin
                    r_pend_vld <= 1'b1;
                end
            end
            if (i_cmd.out_sel != OUT_NONE) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_mode  <= i_in_word.mode;
            r_pos   <= CMP_W'(i_in_word.position);
            r_value <= i_in_word.value;
        end
        if (i_cmd.ins_step || i_cmd.ers_step) begin
            r_wr_addr <= r_idx[ADDR_W-1:0];
        end
        if (i_cmd.find_step && !scan_end) begin
            r_chk_idx <= r_idx[ADDR_W-1:0];
        end
        if (i_cmd.find_step && hit) begin
            r_pend_pos <= CNT_W'(r_chk_idx) + 1'b1;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        r_out_word <= n_out_word;
    end

    // status to the controller
    always_comb begin
        o_sts.mode         = r_mode;
        o_sts.pos_zero     = (r_pos == '0);
        o_sts.pos_past_end = (r_pos > CMP_W'(r_count));
        o_sts.full         = (r_count == CNT_W'(LIST_DEPTH));
        o_sts.ins_more     = (CMP_W'(r_idx) > r_pos);
        o_sts.ers_more     = (CNT_W'(r_idx + 1'b1) < r_count);
        o_sts.wr_pend      = r_wr_pend;
        o_sts.hit          = hit;
        o_sts.pend_vld     = r_pend_vld;
        o_sts.scan_end     = scan_end;
        o_sts.out_free     = out_free;
        o_sts.count        = r_count;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

endmodule

// ===== rtl/olt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olt_ctrl: operation sequencer of the ordered list table
// Decodes the accepted word and steps the datapath through shift, put,
// scan and report phases.
// ----------------------------------------------------------------------------
module olt_ctrl import olt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.mode)
                    MODE_INSERT: begin
                        o_cmd.set_status = 1'b1;
                        if (i_sts.pos_past_end) begin
                            o_cmd.status = ST_RANGE;
                            n_state      = S_REPORT;
                        end else if (i_sts.full) begin
                            o_cmd.status = ST_FULL;
                            n_state      = S_REPORT;
                        end else begin
                            o_cmd.status = ST_OK;
                            o_cmd.setup  = SETUP_INS;
                            n_state      = S_INS_SHIFT;
                        end
                    end
                    MODE_ERASE: begin
                        o_cmd.set_status = 1'b1;
                        if (i_sts.pos_zero || i_sts.pos_past_end) begin
                            o_cmd.status = ST_RANGE;
                            n_state      = S_REPORT;
                        end else begin
                            o_cmd.status = ST_OK;
                            o_cmd.setup  = SETUP_ERS;
                            n_state      = S_ERS_SHIFT;
                        end
                    end
                    MODE_FIND: begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_OK;
                        o_cmd.setup      = SETUP_FIND;
                        n_state          = S_FIND;
                    end
                    MODE_CLEAR: begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_OK;
                        o_cmd.cnt_op     = CNT_CLR;
                        n_state          = S_REPORT;
                    end
                endcase
            end
            // move entries up from the tail, one per cycle
            S_INS_SHIFT: begin
                if (i_sts.ins_more) begin
                    o_cmd.ins_step = 1'b1;
                end else begin
                    n_state = S_INS_PUT;
                end
            end
            // last shift write must land before the new value goes in
            S_INS_PUT: begin
                if (!i_sts.wr_pend) begin
                    o_cmd.put_value = 1'b1;
                    o_cmd.cnt_op    = CNT_INC;
                    n_state         = S_REPORT;
                end
            end
            // move entries down over the erased slot
            S_ERS_SHIFT: begin
                if (i_sts.ers_more) begin
                    o_cmd.ers_step = 1'b1;
                end else begin
                    n_state = S_ERS_END;
                end
            end
            S_ERS_END: begin
                if (!i_sts.wr_pend) begin
                    o_cmd.cnt_op = CNT_DEC;
                    n_state      = S_REPORT;
                end
            end
            // scan; a match is held back until the next one shows whether it is last
            S_FIND: begin
                if (i_sts.hit && i_sts.pend_vld) begin
                    if (i_sts.out_free) begin
                        o_cmd.find_step = 1'b1;
                        o_cmd.out_sel   = OUT_PEND_MID;
                        if (i_sts.scan_end) begin
                            n_state = S_FIND_END;
                        end
                    end
                end else begin
                    o_cmd.find_step = 1'b1;
                    if (i_sts.scan_end) begin
                        n_state = S_FIND_END;
                    end
                end
            end
            S_FIND_END: begin
                if (i_sts.out_free) begin
                    o_cmd.out_sel = i_sts.pend_vld ? OUT_PEND_LAST : OUT_STATUS;
                    n_state       = S_IDLE;
                end
            end
            S_REPORT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_sel = OUT_STATUS;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/ordered_list_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_table_unit: ordered list of signed 64-bit values
// Insert after a position, erase at a position, find by value, clear.
//
//   channel  dir  payload                                         words/item
//   i_in     in   mode, position, value                           1
//   o_out    out  status, match_position, last, entry_total       1 to 32
//
// With a free output, insert and erase make one memory move per cycle and find
// makes one memory read and compare per cycle; clear and rejected items go
// straight from decode to the report.
// The last result word is valid in the same cycle as the next word can be taken.
// One result register decouples the output; a stalled output holds the scan.
// Synchronous active-low reset empties the list; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ordered_list_table_unit import olt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    olt_in_if.sink    i_in,
    olt_out_if.source o_out
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    logic    in_ready;

    assign i_in.ready = in_ready;

    // sequencer
    olt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    // storage and result path
    olt_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_in_word   (i_in.word),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_word  (o_out.word)
    );

`ifndef SYNTHESIS
    // new value is never written over a shift still in flight
    a_put_after_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.put_value |-> !dp_sts.wr_pend)
        else $error("put_value collides with pending shift write");

    // only match words can be followed by more words of the same item
    a_mid_is_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.word.last) |-> (o_out.word.status == ST_MATCH))
        else $error("non-final word without match status");

    // entry count stays within the list depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_sts.count <= CNT_W'(LIST_DEPTH))
        else $error("entry count above list depth");

    // a new word is taken only once all memory moves are done
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ready |-> (!dp_sts.wr_pend && !dp_cmd.find_step))
        else $error("input accepted while list operation active");
`endif

endmodule

// ===== verif/ordered_list_table_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_table_unit_test: self-checking bench for the ordered list table
// An initial block queues list operations: a short directed pass, then random
// fill, drain and mixed sequences over a small pool of values so that finds
// hit several entries. A clocked driver feeds the input channel from that
// queue and predicts the result words of each accepted word. A clocked
// monitor compares each result word with the oldest prediction. Both sides
// idle in random bursts, except near the end of the run.
// ----------------------------------------------------------------------------
module ordered_list_table_unit_test;
    import olt_pkg::*;

    localparam int RANDOM_ITEMS = 340;
    localparam int CALM_TAIL    = 50;       // last words sent with no idling
    localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 16;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int REPORT_MAX   = 10;

    logic i_clk;
    logic i_rst_n;

    olt_in_if  in_ch ();
    olt_out_if out_ch ();

    ordered_list_table_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // clock, 4 ns period
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // words waiting to be sent, and result words still to come
    t_in_word  pend_q[$];
    t_out_word exp_q[$];

    // shadow of the list contents
    logic signed [VAL_W-1:0] list_vals [LIST_DEPTH];
    int                      list_len;

    int  fail_cnt;
    int  cycle_cnt;
    int  gen_len;          // list length as seen by the word generator
    logic calm;

    logic signed [VAL_W-1:0] val_pool [6];

    // works out the result words of one accepted word and updates the shadow
    function automatic void predict_list_op(t_in_word w);
        t_out_word res;
        int        pos;
        int        hits;
        int        k;
        pos  = int'(w.position);
        res  = '0;
        res.status = ST_OK;
        res.last   = 1'b1;
        case (w.mode)
            MODE_INSERT: begin
                if (pos > list_len) begin
                    res.status = ST_RANGE;
                end else if (list_len >= LIST_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    for (int i = list_len; i > pos; i--)
                        list_vals[i] = list_vals[i-1];
                    list_vals[pos] = w.value;
                    list_len++;
                end
            end
            MODE_ERASE: begin
                if (pos == 0 || pos > list_len) begin
                    res.status = ST_RANGE;
                end else begin
                    for (int i = pos - 1; i + 1 < list_len; i++)
                        list_vals[i] = list_vals[i+1];
                    list_len--;
                end
            end
            MODE_FIND: begin
                hits = 0;
                for (int i = 0; i < list_len; i++)
                    if (list_vals[i] == w.value) hits++;
                if (hits > 0) begin
                    k = 0;
                    for (int i = 0; i < list_len; i++) begin
                        if (list_vals[i] == w.value) begin
                            k++;
                            res.status         = ST_MATCH;
                            res.match_position = POS_W'(i + 1);
                            res.last           = (k == hits);
                            res.entry_total    = POS_W'(list_len);
                            exp_q = {exp_q, res};
                        end
                    end
                    return;
                end
            end
            default: begin
                list_len = 0;
            end
        endcase
        res.entry_total = POS_W'(list_len);
        exp_q = {exp_q, res};
    endfunction

    // queue one word and track the list length it leaves behind
    task automatic push_item(t_mode m, int pos, logic signed [VAL_W-1:0] v);
        t_in_word w;
        w.mode     = m;
        w.position = POS_W'(pos);
        w.value    = v;
        pend_q = {pend_q, w};
        case (m)
            MODE_INSERT: if (w.position <= gen_len && gen_len < LIST_DEPTH) gen_len++;
            MODE_ERASE:  if (w.position != 0 && w.position <= gen_len) gen_len--;
            MODE_CLEAR:  gen_len = 0;
            default: ;
        endcase
    endtask

    function automatic logic signed [VAL_W-1:0] rand_word64();
        return {$urandom, $urandom};
    endfunction

    // mostly pool values so that finds see repeated entries
    function automatic logic signed [VAL_W-1:0] pick_value();
        if ($urandom_range(99) < 80) return val_pool[$urandom_range(5)];
        return rand_word64();
    endfunction

    function automatic int ins_pos();
        if ($urandom_range(7) == 0) return $urandom_range(63);
        return $urandom_range(gen_len);
    endfunction

    function automatic int ers_pos();
        if (gen_len == 0 || $urandom_range(7) == 0) return $urandom_range(63);
        return $urandom_range(gen_len, 1);
    endfunction

    // input driver: holds a word until accepted, predicts on acceptance
    int send_gap;
    int send_idle_pct;
    always @(posedge i_clk) begin : drive_proc
        t_in_word next_word;
        logic     next_valid;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            calm        <= 1'b0;
        end else begin
            next_valid = in_ch.valid;
            next_word  = in_ch.word;
            if (in_ch.valid && in_ch.ready) begin
                predict_list_op(in_ch.word);
                void'(pend_q.pop_front());
                next_valid = 1'b0;
            end
            if ($urandom_range(63) == 0)
                send_idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(50, 10);
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pend_q.size() > 0) begin
                    if (pend_q.size() > CALM_TAIL && $urandom_range(99) < send_idle_pct) begin
                        send_gap = $urandom_range(8);
                    end else begin
                        next_valid = 1'b1;
                        next_word  = pend_q[0];
                    end
                end
            end
            in_ch.valid <= next_valid;
            in_ch.word  <= next_word;
            calm        <= (pend_q.size() <= CALM_TAIL);
        end
    end

    // result monitor: compares each result word with the oldest prediction
    int recv_gap;
    int recv_idle_pct;
    always @(posedge i_clk) begin : check_proc
        t_out_word want;
        t_out_word got;
        logic      next_ready;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.word;
                if (exp_q.size() == 0) begin
                    if (fail_cnt < REPORT_MAX)
                        $display("unexpected result word: status %0d pos %0d last %0b total %0d",
                                 got.status, got.match_position, got.last, got.entry_total);
                    fail_cnt++;
                end else begin
                    want = exp_q.pop_front();
                    if (got.status != want.status
                            || got.match_position != want.match_position
                            || got.last != want.last
                            || got.entry_total != want.entry_total) begin
                        if (fail_cnt < REPORT_MAX)
                            $display("result mismatch: expected status %0d pos %0d last %0b ",
                                     want.status, want.match_position, want.last,
                                     "total %0d, got status %0d pos %0d last %0b total %0d",
                                     want.entry_total, got.status, got.match_position,
                                     got.last, got.entry_total);
                        fail_cnt++;
                    end
                end
            end
            if ($urandom_range(63) == 0)
                recv_idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(50, 10);
            if (recv_gap > 0) begin
                recv_gap--;
                next_ready = 1'b0;
            end else if (!calm && $urandom_range(99) < recv_idle_pct) begin
                recv_gap   = $urandom_range(8);
                next_ready = 1'b0;
            end else begin
                next_ready = 1'b1;
            end
            out_ch.ready <= next_ready;
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin : main_proc
        logic signed [VAL_W-1:0] max_v;
        logic signed [VAL_W-1:0] min_v;
        int seg;
        int sel;
        int target;
        max_v = {1'b0, {(VAL_W-1){1'b1}}};
        min_v = {1'b1, {(VAL_W-1){1'b0}}};
        fail_cnt      = 0;
        cycle_cnt     = 0;
        gen_len       = 0;
        list_len      = 0;
        send_gap      = 0;
        recv_gap      = 0;
        send_idle_pct = 20;
        recv_idle_pct = 20;
        calm          = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.word    = '0;
        out_ch.ready  = 1'b0;
        i_rst_n       = 1'b0;

        // directed: empty list cases
        push_item(MODE_FIND,   0, '0);
        push_item(MODE_ERASE,  0, '0);
        push_item(MODE_ERASE,  1, '0);
        push_item(MODE_INSERT, 1, 64'sd5);          // past the end
        // value extremes at front, back and middle
        push_item(MODE_INSERT, 0, max_v);
        push_item(MODE_INSERT, 1, min_v);
        push_item(MODE_INSERT, 0, -64'sd1);
        push_item(MODE_INSERT, 63, 64'sd7);
        push_item(MODE_INSERT, 2, max_v);
        push_item(MODE_FIND,   42, max_v);          // two matches
        push_item(MODE_FIND,   0, min_v);           // one match at the tail
        push_item(MODE_FIND,   0, '0);              // no match
        push_item(MODE_ERASE,  4, '1);              // tail
        push_item(MODE_ERASE,  1, '0);              // head
        push_item(MODE_ERASE,  32, '0);
        push_item(MODE_ERASE,  0, '0);
        push_item(MODE_FIND,   0, max_v);
        push_item(MODE_CLEAR,  63, '1);
        push_item(MODE_FIND,   0, max_v);
        push_item(MODE_CLEAR,  0, '0);

        // random: fill, drain and mixed sequences
        val_pool[0] = max_v;
        val_pool[1] = min_v;
        val_pool[2] = '0;
        val_pool[3] = -64'sd1;
        val_pool[4] = rand_word64();
        val_pool[5] = rand_word64();
        target = pend_q.size() + RANDOM_ITEMS;
        while (pend_q.size() < target) begin
            seg = $urandom_range(9);
            if ($urandom_range(3) == 0) val_pool[$urandom_range(5, 4)] = rand_word64();
            if (seg < 3) begin
                // fill to full, then push against the full list
                while (gen_len < LIST_DEPTH)
                    push_item(MODE_INSERT, $urandom_range(gen_len), pick_value());
                repeat ($urandom_range(3, 1))
                    push_item(MODE_INSERT, $urandom_range(LIST_DEPTH + 1), pick_value());
                repeat ($urandom_range(3, 1))
                    push_item(MODE_FIND, $urandom_range(63), pick_value());
            end else if (seg < 5) begin
                // drain to empty with finds along the way
                while (gen_len > 0) begin
                    if ($urandom_range(4) == 0)
                        push_item(MODE_FIND, $urandom_range(63), pick_value());
                    else
                        push_item(MODE_ERASE, $urandom_range(gen_len, 1), rand_word64());
                end
                push_item(MODE_ERASE, $urandom_range(63), rand_word64());
            end else begin
                repeat ($urandom_range(30, 10)) begin
                    sel = $urandom_range(99);
                    if (sel < 10)
                        push_item(t_mode'($urandom_range(3)), $urandom_range(63),
                                  rand_word64());
                    else if (sel < 50)
                        push_item(MODE_INSERT, ins_pos(), pick_value());
                    else if (sel < 72)
                        push_item(MODE_ERASE, ers_pos(), rand_word64());
                    else if (sel < 97)
                        push_item(MODE_FIND, $urandom_range(63), pick_value());
                    else
                        push_item(MODE_CLEAR, $urandom_range(63), rand_word64());
                end
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for all words to go out and all results to come back
        while (pend_q.size() != 0) @(posedge i_clk);
        while (exp_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_cnt == 0 && exp_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/olt_pkg.sv
rtl/olt_if.sv
rtl/olt_datapath.sv
rtl/olt_ctrl.sv
rtl/ordered_list_table_unit.sv
verif/ordered_list_table_unit_test.sv
